FILE: hw/rtl/rapq_pkg.sv
// ----------------------------------------------------------------------------
// rapq_pkg
// Shared types and constants for the range-assign point-query tree: command
// and status codes, the item and result payloads, and the sequencer states.
// ----------------------------------------------------------------------------
package rapq_pkg;

	localparam int LEAVES_DEF     = 1024;
	localparam int VALUE_BITS_DEF = 32;
	localparam int STAMP_BITS_DEF = 32;

	localparam int CMD_W     = 2;
	localparam int BOUND_W   = 11;
	localparam int INDEX_W   = 10;
	localparam int DATA_W    = 32;
	localparam int CFG_IDX_W = 1;

	localparam logic [BOUND_W-1:0] ENTRY_COUNT_RST = 11'd1024;

	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_VALUE  = 1'd1;

	typedef enum logic [CMD_W-1:0] {
		CMD_RANGE = 2'd0,
		CMD_POINT = 2'd1,
		CMD_ALL   = 2'd2,
		CMD_QUERY = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_BOUNDS    = 2'd1,
		STATUS_EXHAUSTED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RANGE,
		ST_QUERY
	} state_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [BOUND_W-1:0] range_left;
		logic [BOUND_W-1:0] range_right;
		logic [INDEX_W-1:0] point_index;
		logic [DATA_W-1:0]  new_value;
	} item_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_value;
		status_t           status;
	} result_t;

endpackage

FILE: hw/rtl/range_assign_point_query_tree.sv
// ----------------------------------------------------------------------------
// range_assign_point_query_tree
// Tree of stamped nodes over LEAVES leaves: range, point and whole-array
// assigns stamp covering nodes; a point query walks leaf to root for the
// newest stamp.
// ----------------------------------------------------------------------------
// Completion: point assign, assign all and rejected commands finish in the cycle
// after the transfer; a query reads one node per tree level, from leaf to root;
// a range assign walks both bounds up the tree, stamping the covering nodes.
// Throughput: one command at a time; the next transfer may come in the cycle
// that carries done. The receiver cannot stall results.
// Reset: a sweep that clears all 2*LEAVES node stamps holds busy high.
module range_assign_point_query_tree
	import rapq_pkg::*;
#(
	parameter int LEAVES     = LEAVES_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int STAMP_BITS = STAMP_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  item_t                item,
	output logic                 done,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data
);

	localparam int DEPTH  = 2 * LEAVES;
	localparam int NB     = $clog2(DEPTH);
	localparam int LW     = NB + 1;
	localparam int WIDE_W = (VALUE_BITS > DATA_W) ? VALUE_BITS : DATA_W;

	localparam logic [NB-1:0] ROOT_NODE = NB'(1);

	state_t              state_q, state_d;
	logic                done_q, done_d;
	result_t             result_q, result_d;
	cmd_t                cmd_q;
	logic [BOUND_W-1:0]  entry_count_q;
	logic [DATA_W-1:0]   init_value_q;
	logic [STAMP_BITS-1:0] update_clock_q;
	logic                clock_inc;

	logic [LW-1:0]         l_q, r_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [NB-1:0]         k_q;
	logic                  pend_s1;
	logic [STAMP_BITS-1:0] best_q;
	logic [VALUE_BITS-1:0] ans_q;

	logic                  accept;
	logic                  mem_clearing;
	logic                  wr_en, rd_en;
	logic [NB-1:0]         wr_addr;
	logic [STAMP_BITS-1:0] wr_stamp;
	logic [VALUE_BITS-1:0] wr_value;
	logic [STAMP_BITS-1:0] rd_stamp;
	logic [VALUE_BITS-1:0] rd_value;

	logic [BOUND_W-1:0]    n_use;
	logic                  idx_bad, range_bad, bound_bad, clock_full;
	logic [NB-1:0]         leaf_addr;
	logic [WIDE_W-1:0]     new_wide, init_wide, ans_wide;
	logic [VALUE_BITS-1:0] new_val, init_val;
	logic                  rng_live, rng_l, rng_r;

	rapq_node_mem #(
		.DEPTH (DEPTH),
		.AW    (NB),
		.SW    (STAMP_BITS),
		.VW    (VALUE_BITS)
	) u_node_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_stamp (wr_stamp),
		.wr_value (wr_value),
		.rd_en    (rd_en),
		.rd_addr  (k_q),
		.rd_stamp (rd_stamp),
		.rd_value (rd_value),
		.clearing (mem_clearing)
	);

	assign busy      = (state_q != ST_IDLE) || mem_clearing;
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;

	assign n_use      = (int'(entry_count_q) < LEAVES) ? entry_count_q : BOUND_W'(LEAVES);
	assign idx_bad    = ({1'b0, item.point_index} >= n_use);
	assign range_bad  = !((item.range_left <= item.range_right) && (item.range_right <= n_use));
	assign clock_full = (update_clock_q == {STAMP_BITS{1'b1}});
	assign leaf_addr  = NB'(LEAVES) + NB'(item.point_index);

	assign new_wide  = WIDE_W'(item.new_value);
	assign new_val   = new_wide[VALUE_BITS-1:0];
	assign init_wide = WIDE_W'(init_value_q);
	assign init_val  = init_wide[VALUE_BITS-1:0];
	assign ans_wide  = WIDE_W'(ans_q);

	assign rng_live = (l_q < r_q);
	assign rng_l    = rng_live && l_q[0];
	assign rng_r    = rng_live && !l_q[0] && r_q[0];

	always_comb begin
		bound_bad = 1'b0;
		if (item.cmd == CMD_RANGE) begin
			bound_bad = range_bad;
		end else if (item.cmd inside {CMD_POINT, CMD_QUERY}) begin
			bound_bad = idx_bad;
		end
	end

	always_comb begin
		state_d   = state_q;
		done_d    = 1'b0;
		result_d  = '{read_value: '0, status: STATUS_OK};
		clock_inc = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = ROOT_NODE;
		wr_stamp  = update_clock_q;
		wr_value  = val_q;
		rd_en     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (bound_bad) begin
						done_d          = 1'b1;
						result_d.status = STATUS_BOUNDS;
					end else if (item.cmd == CMD_QUERY) begin
						state_d = ST_QUERY;
					end else if (clock_full) begin
						done_d          = 1'b1;
						result_d.status = STATUS_EXHAUSTED;
					end else begin
						clock_inc = 1'b1;
						wr_stamp  = update_clock_q + 1'b1;
						wr_value  = new_val;
						case (item.cmd)
							CMD_RANGE: begin
								state_d = ST_RANGE;
							end
							CMD_POINT: begin
								wr_en   = 1'b1;
								wr_addr = leaf_addr;
								done_d  = 1'b1;
							end
							default: begin
								wr_en   = 1'b1;
								wr_addr = ROOT_NODE;
								done_d  = 1'b1;
							end
						endcase
					end
				end
			end
			ST_RANGE: begin
				if (rng_l) begin
					wr_en   = 1'b1;
					wr_addr = l_q[NB-1:0];
				end else if (rng_r) begin
					wr_en   = 1'b1;
					wr_addr = NB'(r_q - 1'b1);
				end else if (!rng_live) begin
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_QUERY: begin
				if (k_q != '0) begin
					rd_en = 1'b1;
				end else if (!pend_s1) begin
					done_d              = 1'b1;
					result_d.read_value = ans_wide[DATA_W-1:0];
					state_d             = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			done_q         <= 1'b0;
			pend_s1        <= 1'b0;
			update_clock_q <= '0;
			entry_count_q  <= ENTRY_COUNT_RST;
			init_value_q   <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			pend_s1 <= rd_en;
			if (clock_inc) begin
				update_clock_q <= update_clock_q + 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ENTRY_COUNT: entry_count_q <= cfg_data[BOUND_W-1:0];
					REG_INIT_VALUE:  init_value_q  <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done_d) begin
			result_q <= result_d;
		end
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_q  <= item.cmd;
					l_q    <= LW'(LEAVES) + LW'(item.range_left);
					r_q    <= LW'(LEAVES) + LW'(item.range_right);
					val_q  <= new_val;
					k_q    <= leaf_addr;
					best_q <= '0;
					ans_q  <= init_val;
				end
			end
			ST_RANGE: begin
				if (rng_l) begin
					l_q <= l_q + 1'b1;
				end else if (rng_r) begin
					r_q <= r_q - 1'b1;
				end else if (rng_live) begin
					l_q <= l_q >> 1;
					r_q <= r_q >> 1;
				end
			end
			ST_QUERY: begin
				if (k_q != '0) begin
					k_q <= k_q >> 1;
				end
				if (pend_s1 && (rd_stamp > best_q)) begin
					best_q <= rd_stamp;
					ans_q  <= rd_value;
				end
			end
			default: begin
			end
		endcase
	end

	a_no_work_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !mem_clearing)
		else $error("command in progress during stamp clearing");

	a_exhausted_clock_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (result_q.status == STATUS_EXHAUSTED)) |-> clock_full)
		else $error("exhausted status with clock not full");

	a_value_only_on_query: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (result_q.read_value != '0)) |-> (cmd_q == CMD_QUERY))
		else $error("nonzero read value on an assign");

	a_clock_stable_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_RANGE) && ($past(state_q) == ST_RANGE)) |-> $stable(update_clock_q))
		else $error("clock advanced during range walk");

endmodule

FILE: hw/rtl/rapq_node_mem.sv
// ----------------------------------------------------------------------------
// rapq_node_mem
// Node store of the tree: a stamp memory and a value memory sharing one write
// port and one registered read port. After reset a sweep clears every stamp.
// ----------------------------------------------------------------------------
module rapq_node_mem #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11,
	parameter int SW    = 32,
	parameter int VW    = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [SW-1:0] wr_stamp,
	input  logic [VW-1:0] wr_value,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [SW-1:0] rd_stamp,
	output logic [VW-1:0] rd_value,
	output logic          clearing
);

	logic [SW-1:0] stamp_mem [DEPTH];
	logic [VW-1:0] value_mem [DEPTH];

	logic [AW-1:0] clr_addr_q;
	logic          clearing_q;
	logic [SW-1:0] rd_stamp_q;
	logic [VW-1:0] rd_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			stamp_mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			stamp_mem[wr_addr] <= wr_stamp;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && !clearing_q) begin
			value_mem[wr_addr] <= wr_value;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_stamp_q <= stamp_mem[rd_addr];
			rd_value_q <= value_mem[rd_addr];
		end
	end

	assign rd_stamp = rd_stamp_q;
	assign rd_value = rd_value_q;
	assign clearing = clearing_q;

endmodule
